/* hdl/cgrg_pkg.sv */
// ----------------------------------------------------------------------------
// cgrg_pkg
// Shared types, constants and segment helpers of the color gradient ramp.
// ----------------------------------------------------------------------------
package cgrg_pkg;

    localparam int INDEX_WIDTH_DEFAULT = 16;
    localparam int FIELD_WIDTH         = 16;
    localparam int COLOR_WIDTH         = 24;
    localparam int CHAN_WIDTH          = 8;
    localparam int NUM_CHANS           = 3;
    localparam int NUM_STOPS           = 5;
    localparam int CFG_INDEX_WIDTH     = 3;

    localparam int FRAC_BITS           = 16;
    localparam int POS_WIDTH           = FRAC_BITS + 1;
    localparam int DIV_BITS_PER_STAGE  = 4;
    localparam int DIV_STAGES          = FRAC_BITS / DIV_BITS_PER_STAGE;

    localparam int SEG_OFS_WIDTH       = 15;
    localparam int RECIP_WIDTH         = 19;
    localparam int PROD1_WIDTH         = SEG_OFS_WIDTH + RECIP_WIDTH;
    localparam int PROD2_WIDTH         = POS_WIDTH + SEG_OFS_WIDTH;
    localparam int MIX_PROD_WIDTH      = CHAN_WIDTH + POS_WIDTH;
    localparam int MIX_SUM_WIDTH       = MIX_PROD_WIDTH + 1;
    localparam int MIX_VAL_WIDTH       = MIX_SUM_WIDTH - FRAC_BITS;

    localparam logic [POS_WIDTH-1:0] POS_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [POS_WIDTH-1:0] TH_1 = 17'd19661;
    localparam logic [POS_WIDTH-1:0] TH_2 = 17'd32768;
    localparam logic [POS_WIDTH-1:0] TH_3 = 17'd45875;

    localparam int SEG_W_OUTER = 19661;
    localparam int SEG_W_INNER = 13107;

    // floor(2^32 / width), off by at most one after the shift
    localparam logic [RECIP_WIDTH-1:0] RECIP_OUTER =
        RECIP_WIDTH'((64'd1 << (2 * FRAC_BITS)) / 64'(SEG_W_OUTER));
    localparam logic [RECIP_WIDTH-1:0] RECIP_INNER =
        RECIP_WIDTH'((64'd1 << (2 * FRAC_BITS)) / 64'(SEG_W_INNER));

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NUM_COLORS = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STOP0      = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STOP1      = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STOP2      = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STOP3      = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STOP4      = 3'd5;

    typedef logic [NUM_STOPS-1:0][COLOR_WIDTH-1:0] stop_colors_t;

    localparam logic [FIELD_WIDTH-1:0] NUM_COLORS_RESET = 16'd20;
    localparam stop_colors_t STOP_COLORS_RESET = {
        24'hFFAF00, 24'hFF2400, 24'hFF69B4, 24'h800080, 24'h00A8FF
    };

    typedef enum logic [1:0] {
        SEG_0 = 2'd0,
        SEG_1 = 2'd1,
        SEG_2 = 2'd2,
        SEG_3 = 2'd3
    } seg_t;

    typedef struct packed {
        logic active;
        logic one;
    } pos_ovr_t;

    function automatic logic [POS_WIDTH-1:0] seg_start(seg_t seg);
        case (seg)
            SEG_0:   return '0;
            SEG_1:   return TH_1;
            SEG_2:   return TH_2;
            SEG_3:   return TH_3;
            default: return '0;
        endcase
    endfunction

    function automatic logic [SEG_OFS_WIDTH-1:0] seg_width(seg_t seg);
        case (seg)
            SEG_0, SEG_3: return SEG_OFS_WIDTH'(SEG_W_OUTER);
            SEG_1, SEG_2: return SEG_OFS_WIDTH'(SEG_W_INNER);
            default:      return SEG_OFS_WIDTH'(SEG_W_OUTER);
        endcase
    endfunction

    function automatic logic [RECIP_WIDTH-1:0] seg_recip(seg_t seg);
        case (seg)
            SEG_0, SEG_3: return RECIP_OUTER;
            SEG_1, SEG_2: return RECIP_INNER;
            default:      return RECIP_OUTER;
        endcase
    endfunction

endpackage

/* hdl/cgrg_divider.sv */
// ----------------------------------------------------------------------------
// cgrg_divider
// Pipelined restoring divider: position = (index << 16) / divisor, four
// quotient bits per stage, with override to zero or one carried alongside.
// ----------------------------------------------------------------------------
module cgrg_divider
    import cgrg_pkg::*;
#(
    parameter int IW = INDEX_WIDTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [IW-1:0]        in_dividend,
    input  logic [IW-1:0]        in_divisor,
    input  pos_ovr_t             in_ovr,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [POS_WIDTH-1:0] out_pos
);

    localparam int LAST = DIV_STAGES - 1;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] stage_ready;
    logic [IW-1:0]         rem_reg  [DIV_STAGES];
    logic [IW-1:0]         dvsr_reg [DIV_STAGES];
    logic [FRAC_BITS-1:0]  quo_reg  [DIV_STAGES];
    pos_ovr_t              ovr_reg  [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic                 valid_src;
        logic [IW-1:0]        rem_src;
        logic [IW-1:0]        dvsr_src;
        logic [FRAC_BITS-1:0] quo_src;
        pos_ovr_t             ovr_src;
        logic [IW-1:0]        rem_next;
        logic [FRAC_BITS-1:0] quo_next;
        logic [IW:0]          shifted;

        if (k == 0) begin : g_first
            assign valid_src = in_valid;
            assign rem_src   = in_dividend;
            assign dvsr_src  = in_divisor;
            assign quo_src   = '0;
            assign ovr_src   = in_ovr;
        end else begin : g_next
            assign valid_src = valid_reg[k-1];
            assign rem_src   = rem_reg[k-1];
            assign dvsr_src  = dvsr_reg[k-1];
            assign quo_src   = quo_reg[k-1];
            assign ovr_src   = ovr_reg[k-1];
        end

        if (k == LAST) begin : g_ready_last
            assign stage_ready[k] = !valid_reg[k] || out_ready;
        end else begin : g_ready_mid
            assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end

        always_comb begin
            rem_next = rem_src;
            quo_next = quo_src;
            shifted  = '0;
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
                shifted  = {rem_next, 1'b0};
                quo_next = {quo_next[FRAC_BITS-2:0], (shifted >= {1'b0, dvsr_src})};
                if (quo_next[0]) begin
                    rem_next = IW'(shifted - {1'b0, dvsr_src});
                end else begin
                    rem_next = shifted[IW-1:0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (stage_ready[k]) begin
                valid_reg[k] <= valid_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[k]) begin
                rem_reg[k]  <= rem_next;
                dvsr_reg[k] <= dvsr_src;
                quo_reg[k]  <= quo_next;
                ovr_reg[k]  <= ovr_src;
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[LAST];

    always_comb begin
        if (ovr_reg[LAST].active) begin
            out_pos = ovr_reg[LAST].one ? POS_ONE : '0;
        end else begin
            out_pos = {1'b0, quo_reg[LAST]};
        end
    end

    // partial remainder stays below the divisor on a real division
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[LAST] && !ovr_reg[LAST].active) |-> (rem_reg[LAST] < dvsr_reg[LAST]))
        else $error("divider remainder not below divisor");

endmodule

/* hdl/cgrg_frac.sv */
// ----------------------------------------------------------------------------
// cgrg_frac
// Finds the ramp segment of a position and the local Q1.16 fraction within
// it, dividing by the constant segment width through a reciprocal multiply.
// ----------------------------------------------------------------------------
module cgrg_frac
    import cgrg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [POS_WIDTH-1:0] in_pos,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [POS_WIDTH-1:0] out_frac,
    output seg_t                 out_seg
);

    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic a_ready, b_ready, c_ready, d_ready;

    seg_t                     seg_next;
    logic [SEG_OFS_WIDTH-1:0] ofs_next;
    seg_t                     seg_a_reg, seg_b_reg, seg_c_reg, seg_d_reg;
    logic [SEG_OFS_WIDTH-1:0] ofs_a_reg, ofs_b_reg, ofs_c_reg;
    logic [PROD1_WIDTH-1:0]   prod1_b_reg;
    logic [POS_WIDTH-1:0]     quo0_next;
    logic [POS_WIDTH-1:0]     quo0_c_reg;
    logic [PROD2_WIDTH-1:0]   prod2_c_reg;
    logic [PROD2_WIDTH-1:0]   rem;
    logic [PROD2_WIDTH-1:0]   width_c;
    logic [POS_WIDTH-1:0]     frac_next;
    logic [POS_WIDTH-1:0]     frac_d_reg;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // a border position belongs to the lower segment
    always_comb begin
        if (in_pos <= TH_1) begin
            seg_next = SEG_0;
        end else if (in_pos <= TH_2) begin
            seg_next = SEG_1;
        end else if (in_pos <= TH_3) begin
            seg_next = SEG_2;
        end else begin
            seg_next = SEG_3;
        end
        ofs_next = SEG_OFS_WIDTH'(in_pos - seg_start(seg_next));
    end

    assign quo0_next = POS_WIDTH'(prod1_b_reg >> FRAC_BITS);
    assign width_c   = PROD2_WIDTH'(seg_width(seg_c_reg));
    assign rem       = {1'b0, ofs_c_reg, {FRAC_BITS{1'b0}}} - prod2_c_reg;
    assign frac_next = (rem >= width_c) ? quo0_c_reg + 1'b1 : quo0_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            seg_a_reg <= seg_next;
            ofs_a_reg <= ofs_next;
        end
        if (b_ready) begin
            seg_b_reg   <= seg_a_reg;
            ofs_b_reg   <= ofs_a_reg;
            prod1_b_reg <= PROD1_WIDTH'(ofs_a_reg) * PROD1_WIDTH'(seg_recip(seg_a_reg));
        end
        if (c_ready) begin
            seg_c_reg   <= seg_b_reg;
            ofs_c_reg   <= ofs_b_reg;
            quo0_c_reg  <= quo0_next;
            prod2_c_reg <= PROD2_WIDTH'(quo0_next) * PROD2_WIDTH'(seg_width(seg_b_reg));
        end
        if (d_ready) begin
            seg_d_reg  <= seg_c_reg;
            frac_d_reg <= frac_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_frac  = frac_d_reg;
    assign out_seg   = seg_d_reg;

    // reciprocal estimate is short by at most one
    a_rem_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg |-> (rem < (width_c << 1)))
        else $error("reciprocal correction out of range");

    a_frac_max: assert property (@(posedge aclk) disable iff (!aresetn)
        d_valid_reg |-> (frac_d_reg <= POS_ONE))
        else $error("fraction above one");

endmodule

/* hdl/cgrg_mix.sv */
// ----------------------------------------------------------------------------
// cgrg_mix
// Blends the two stop colors of a segment by the local fraction, one
// multiplier pair per channel, then sums, floors and clamps.
// ----------------------------------------------------------------------------
module cgrg_mix
    import cgrg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  stop_colors_t          stop_colors,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [POS_WIDTH-1:0]  in_frac,
    input  seg_t                  in_seg,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CHAN_WIDTH-1:0] out_red,
    output logic [CHAN_WIDTH-1:0] out_green,
    output logic [CHAN_WIDTH-1:0] out_blue
);

    logic e_valid_reg, f_valid_reg;
    logic e_ready, f_ready;

    logic [COLOR_WIDTH-1:0]    color_a;
    logic [COLOR_WIDTH-1:0]    color_b;
    logic [POS_WIDTH-1:0]      frac_inv;
    logic [MIX_PROD_WIDTH-1:0] pa_next [NUM_CHANS];
    logic [MIX_PROD_WIDTH-1:0] pb_next [NUM_CHANS];
    logic [MIX_PROD_WIDTH-1:0] pa_reg  [NUM_CHANS];
    logic [MIX_PROD_WIDTH-1:0] pb_reg  [NUM_CHANS];
    logic [CHAN_WIDTH-1:0]     chan_next [NUM_CHANS];
    logic [CHAN_WIDTH-1:0]     chan_reg  [NUM_CHANS];

    assign f_ready  = !f_valid_reg || out_ready;
    assign e_ready  = !e_valid_reg || f_ready;
    assign in_ready = e_ready;

    always_comb begin
        case (in_seg)
            SEG_0: begin
                color_a = stop_colors[0];
                color_b = stop_colors[1];
            end
            SEG_1: begin
                color_a = stop_colors[1];
                color_b = stop_colors[2];
            end
            SEG_2: begin
                color_a = stop_colors[2];
                color_b = stop_colors[3];
            end
            SEG_3: begin
                color_a = stop_colors[3];
                color_b = stop_colors[4];
            end
            default: begin
                color_a = stop_colors[0];
                color_b = stop_colors[1];
            end
        endcase
    end

    assign frac_inv = POS_ONE - in_frac;

    always_comb begin
        for (int ch = 0; ch < NUM_CHANS; ch++) begin
            pa_next[ch] = MIX_PROD_WIDTH'(color_a[ch*CHAN_WIDTH +: CHAN_WIDTH])
                        * MIX_PROD_WIDTH'(frac_inv);
            pb_next[ch] = MIX_PROD_WIDTH'(color_b[ch*CHAN_WIDTH +: CHAN_WIDTH])
                        * MIX_PROD_WIDTH'(in_frac);
        end
    end

    always_comb begin
        logic [MIX_SUM_WIDTH-1:0] sum;
        logic [MIX_VAL_WIDTH-1:0] val;
        for (int ch = 0; ch < NUM_CHANS; ch++) begin
            sum = MIX_SUM_WIDTH'(pa_reg[ch]) + MIX_SUM_WIDTH'(pb_reg[ch]);
            val = MIX_VAL_WIDTH'(sum >> FRAC_BITS);
            chan_next[ch] = (val > MIX_VAL_WIDTH'({CHAN_WIDTH{1'b1}})) ?
                            {CHAN_WIDTH{1'b1}} : val[CHAN_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else begin
            if (e_ready) begin
                e_valid_reg <= in_valid;
            end
            if (f_ready) begin
                f_valid_reg <= e_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (e_ready) begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
        if (f_ready) begin
            chan_reg <= chan_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_red   = chan_reg[2];
    assign out_green = chan_reg[1];
    assign out_blue  = chan_reg[0];

endmodule

/* hdl/color_gradient_ramp_generator_core.sv */
// ----------------------------------------------------------------------------
// color_gradient_ramp_generator_core
// Five-stop linear color ramp: color index in, interpolated RGB out.
// ----------------------------------------------------------------------------
// Takes one color index per clock while the output is not stalled and returns
// one RGB beat per index, in order, through one input stage, four divider stages
// (four quotient bits each), four stages of segment lookup and reciprocal
// division by the segment width, and two blend stages ending in the output
// register. Sustained rate is one beat per clock when the output is not
// stalled, set by the fully pipelined divider. A stall at the output fills the
// pipeline bubbles before s_ready drops. Configuration registers are read
// live by the pipeline, so write them only while no beat is in flight.
// ----------------------------------------------------------------------------
module color_gradient_ramp_generator_core
    import cgrg_pkg::*;
#(
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COLOR_WIDTH-1:0]     cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [FIELD_WIDTH-1:0]     s_color_index,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [CHAN_WIDTH-1:0]      m_red,
    output logic [CHAN_WIDTH-1:0]      m_green,
    output logic [CHAN_WIDTH-1:0]      m_blue
);

    localparam int IW = (INDEX_WIDTH < FIELD_WIDTH) ? INDEX_WIDTH : FIELD_WIDTH;

    logic [FIELD_WIDTH-1:0] num_colors_reg, num_colors_next;
    stop_colors_t           stop_colors_reg, stop_colors_next;

    logic [IW-1:0] idx;
    logic [IW-1:0] ncol;
    logic [IW-1:0] dvsr_next;
    pos_ovr_t      ovr_next;

    logic          in_valid_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] dvsr_reg;
    pos_ovr_t      ovr_reg;

    logic                 div_in_ready;
    logic                 div_out_valid;
    logic                 div_out_ready;
    logic [POS_WIDTH-1:0] div_pos;

    logic                 frac_out_valid;
    logic                 frac_out_ready;
    logic [POS_WIDTH-1:0] frac_val;
    seg_t                 frac_seg;

    always_comb begin
        num_colors_next  = num_colors_reg;
        stop_colors_next = stop_colors_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_NUM_COLORS: num_colors_next    = cfg_wdata[FIELD_WIDTH-1:0];
                REG_STOP0:      stop_colors_next[0] = cfg_wdata;
                REG_STOP1:      stop_colors_next[1] = cfg_wdata;
                REG_STOP2:      stop_colors_next[2] = cfg_wdata;
                REG_STOP3:      stop_colors_next[3] = cfg_wdata;
                REG_STOP4:      stop_colors_next[4] = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_colors_reg  <= NUM_COLORS_RESET;
            stop_colors_reg <= STOP_COLORS_RESET;
        end else begin
            num_colors_reg  <= num_colors_next;
            stop_colors_reg <= stop_colors_next;
        end
    end

    // single color or none pins the position to zero, last index or past to one
    assign idx       = s_color_index[IW-1:0];
    assign ncol      = num_colors_reg[IW-1:0];
    assign dvsr_next = ncol - IW'(1);

    always_comb begin
        ovr_next.active = (ncol <= IW'(1)) || (idx >= dvsr_next);
        ovr_next.one    = (ncol > IW'(1));
    end

    assign s_ready = !in_valid_reg || div_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            idx_reg  <= idx;
            dvsr_reg <= dvsr_next;
            ovr_reg  <= ovr_next;
        end
    end

    cgrg_divider #(
        .IW (IW)
    ) u_divider (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (in_valid_reg),
        .in_ready    (div_in_ready),
        .in_dividend (idx_reg),
        .in_divisor  (dvsr_reg),
        .in_ovr      (ovr_reg),
        .out_valid   (div_out_valid),
        .out_ready   (div_out_ready),
        .out_pos     (div_pos)
    );

    cgrg_frac u_frac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_out_valid),
        .in_ready  (div_out_ready),
        .in_pos    (div_pos),
        .out_valid (frac_out_valid),
        .out_ready (frac_out_ready),
        .out_frac  (frac_val),
        .out_seg   (frac_seg)
    );

    cgrg_mix u_mix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .stop_colors (stop_colors_reg),
        .in_valid    (frac_out_valid),
        .in_ready    (frac_out_ready),
        .in_frac     (frac_val),
        .in_seg      (frac_seg),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_red     (m_red),
        .out_green   (m_green),
        .out_blue    (m_blue)
    );

    // backpressure only ever starts at a stalled output beat
    a_stall_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a stalled output");

endmodule
